>>> rtl/rtpdp_pkg.sv
// Shared types and constants for the RGB pixel packer.
// Used by every rtpdp_* module and the top level; no dependencies.
`default_nettype none
package rtpdp_pkg;

    localparam int PIX_W   = 24;
    localparam int WORD_W  = 32;
    localparam int NB_W    = 3;
    localparam int FMT_W   = 3;
    localparam int CNT_W   = 2;
    localparam int ACC_W   = 56;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // out_format codes; unused codes fall into passthrough
    localparam logic [FMT_W-1:0] FMT_RGB555 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 3'd2;
    localparam logic [FMT_W-1:0] FMT_BGR24  = 3'd3;
    localparam logic [FMT_W-1:0] FMT_PASS32 = 3'd4;

    localparam logic [NB_W-1:0] NB_FULL = 3'd4;

    // One queue entry: the words one item produces
    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [NB_W-1:0]   nb0;
        logic              le0;
        logic              two;     // a flush word follows w0
        logic [PIX_W-1:0]  w1;      // flush word, upper byte always zero
        logic [NB_W-1:0]   nb1;
    } t_job;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage
`default_nettype wire

>>> rtl/rtpdp_front.sv
// Front part: format register, pixel encoding and byte accumulator.
// Depends on rtpdp_pkg; pushes one job per word-producing item.
`default_nettype none
module rtpdp_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [rtpdp_pkg::FMT_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [rtpdp_pkg::PIX_W-1:0] i_pixel_rgb,
    input  wire logic                       i_end_of_line,
    input  wire rtpdp_pkg::t_q_status       i_q_status,
    output rtpdp_pkg::t_push                o_push
);
    import rtpdp_pkg::*;

    logic [FMT_W-1:0]  r_out_format;
    logic [PIX_W-1:0]  r_pending;
    logic [CNT_W-1:0]  r_count;
    logic [PIX_W-1:0]  n_pending;
    logic [CNT_W-1:0]  n_count;

    logic              accept;
    logic [PIX_W-1:0]  enc;
    logic [NB_W-1:0]   nb;
    logic [ACC_W-1:0]  acc;
    logic [NB_W-1:0]   total;
    logic [NB_W-1:0]   rem;
    t_push             push;

    assign accept     = i_in_valid && !i_q_status.full;
    assign o_in_stall = i_q_status.full;

    always_comb begin
        unique case (r_out_format)
            FMT_RGB555: begin
                enc = {9'd0, i_pixel_rgb[23:19], i_pixel_rgb[15:11], i_pixel_rgb[7:3]};
                nb  = 3'd2;
            end
            FMT_RGB565: begin
                enc = {8'd0, i_pixel_rgb[23:19], i_pixel_rgb[15:10], i_pixel_rgb[7:3]};
                nb  = 3'd2;
            end
            FMT_RGB24: begin
                enc = {i_pixel_rgb[7:0], i_pixel_rgb[15:8], i_pixel_rgb[23:16]};
                nb  = 3'd3;
            end
            FMT_BGR24: begin
                enc = i_pixel_rgb;
                nb  = 3'd3;
            end
            default: begin
                enc = i_pixel_rgb;
                nb  = NB_FULL;
            end
        endcase
    end

    // append new bytes above the pending ones
    always_comb begin
        acc   = {{(ACC_W-PIX_W){1'b0}}, r_pending}
              | ({{(ACC_W-PIX_W){1'b0}}, enc} << {r_count, 3'b000});
        total = {1'b0, r_count} + nb;
        rem   = total - NB_FULL;
    end

    always_comb begin
        push.vld     = 1'b0;
        push.job.w0  = acc[WORD_W-1:0];
        push.job.nb0 = total;
        push.job.le0 = i_end_of_line;
        push.job.two = 1'b0;
        push.job.w1  = acc[ACC_W-1:WORD_W];
        push.job.nb1 = rem;
        n_pending    = r_pending;
        n_count      = r_count;
        if (total >= NB_FULL) begin
            push.vld     = accept;
            push.job.nb0 = NB_FULL;
            push.job.le0 = i_end_of_line && (rem == '0);
            push.job.two = i_end_of_line && (rem != '0);
            if (accept) begin
                if (i_end_of_line || rem == '0) begin
                    n_pending = '0;
                    n_count   = '0;
                end else begin
                    n_pending = acc[ACC_W-1:WORD_W];
                    n_count   = rem[CNT_W-1:0];
                end
            end
        end else begin
            // total is 2 or 3 here; a line end flushes it
            push.vld = accept && i_end_of_line;
            if (accept) begin
                if (i_end_of_line) begin
                    n_pending = '0;
                    n_count   = '0;
                end else begin
                    n_pending = acc[PIX_W-1:0];
                    n_count   = total[CNT_W-1:0];
                end
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_format <= FMT_PASS32;
            r_pending    <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_out_format <= i_cfg_wdata;
            end
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rtpdp_queue.sv
// Short job queue between front and back parts, register based.
// Depends on rtpdp_pkg; push and pop may happen in the same cycle.
`default_nettype none
module rtpdp_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rtpdp_pkg::t_push     i_push,
    input  wire logic                 i_pop,
    output rtpdp_pkg::t_job           o_head,
    output rtpdp_pkg::t_q_status      o_status
);
    import rtpdp_pkg::*;

    t_job               r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign do_push = i_push.vld && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

>>> rtl/rtpdp_back.sv
// Back part: splits each job into one or two words into the output register.
// Depends on rtpdp_pkg; pops the queue on the last word of a job.
`default_nettype none
module rtpdp_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rtpdp_pkg::t_job               i_head,
    input  wire rtpdp_pkg::t_q_status          i_q_status,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rtpdp_pkg::WORD_W-1:0]       o_out_word,
    output logic [rtpdp_pkg::NB_W-1:0]         o_valid_bytes,
    output logic                               o_line_end,
    output logic                               o_run_last
);
    import rtpdp_pkg::*;

    logic               r_phase;    // 1: flush word of the head job is next
    logic               r_valid;
    logic [WORD_W-1:0]  r_word;
    logic [NB_W-1:0]    r_nb;
    logic               r_le;
    logic               r_last;
    logic               load;
    logic               take;

    assign load  = !r_valid || !i_out_stall;
    assign take  = load && !i_q_status.empty;
    assign o_pop = take && (r_phase || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (take) begin
                r_phase <= !r_phase && i_head.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_phase) begin
                r_word <= {{(WORD_W-PIX_W){1'b0}}, i_head.w1};
                r_nb   <= i_head.nb1;
                r_le   <= 1'b1;
                r_last <= 1'b1;
            end else begin
                r_word <= i_head.w0;
                r_nb   <= i_head.nb0;
                r_le   <= i_head.le0;
                r_last <= !i_head.two;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_word    = r_word;
    assign o_valid_bytes = r_nb;
    assign o_line_end    = r_le;
    assign o_run_last    = r_last;

endmodule
`default_nettype wire

>>> rtl/rgb_to_packed_display_pixels.sv
// Top level of the RGB pixel packer: front, job queue, back.
// Depends on rtpdp_pkg, rtpdp_front, rtpdp_queue and rtpdp_back.
//
// Usage:
//   Input channel: one 24-bit RGB pixel plus end-of-line mark per item,
//   taken at a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: one packed 32-bit word per item, with valid byte count,
//   line-end flag and run_last (last word caused by that pixel); taken at
//   an edge with o_out_valid high and i_out_stall low.
//   Config: i_cfg_we writes i_cfg_wdata into out_format (write while idle).
// Path: the pixel that completes a word pushes its job into the queue; the
//   back part loads it from the queue head into the output register.
// Throughput: one pixel per cycle unless the queue is full. A pixel that
//   yields two words (a full word plus a line-end flush) sends both in turn;
//   the back part emits one word per cycle unless i_out_stall is high.
// Reset: out_format returns to 32-bit passthrough, pending bytes are
//   dropped, queue and output register empty.
// Receiver stall: the output register holds its word; jobs collect in the
//   4-entry queue, and once it is full o_in_stall rises until a pop.
`default_nettype none
module rgb_to_packed_display_pixels (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtpdp_pkg::FMT_W-1:0]   i_cfg_wdata,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [rtpdp_pkg::PIX_W-1:0]   i_pixel_rgb,
    input  wire logic                          i_end_of_line,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rtpdp_pkg::WORD_W-1:0]       o_out_word,
    output logic [rtpdp_pkg::NB_W-1:0]         o_valid_bytes,
    output logic                               o_line_end,
    output logic                               o_run_last
);
    import rtpdp_pkg::*;

    t_push     push;
    t_job      head;
    t_q_status q_status;
    logic      pop;

    // encode + accumulate; pushes a job only when a word is due
    rtpdp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_rgb   (i_pixel_rgb),
        .i_end_of_line (i_end_of_line),
        .i_q_status    (q_status),
        .o_push        (push)
    );

    // decouples packing from the output handshake
    rtpdp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // one word per cycle into the output register while not stalled
    rtpdp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_word    (o_out_word),
        .o_valid_bytes (o_valid_bytes),
        .o_line_end    (o_line_end),
        .o_run_last    (o_run_last)
    );

`ifndef ASSERT_OFF
    // partial words only close a line
    a_partial_only_at_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_end |-> o_valid_bytes == NB_FULL)
        else $error("partial word without line end");

    // the first of two words from one pixel is full and not the line end
    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> o_valid_bytes == NB_FULL && !o_line_end)
        else $error("bad first word of a two-word pixel");

    // a word that is not the last of its pixel is followed by the flush word
    a_flush_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last && !i_out_stall |=> o_out_valid && o_run_last
            && o_line_end)
        else $error("flush word missing after first word");
`endif

endmodule
`default_nettype wire
